@@ rtl/point_segment_distance_angle_macros.svh @@
// Assertion macros for the point to segment distance block.
// A module that uses them has clk_i and rst_ni in scope.
`ifndef POINT_SEGMENT_DISTANCE_ANGLE_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_ANGLE_MACROS_SVH
`ifndef SYNTHESIS
`define PSDA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
`define PSDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define PSDA_ASSERT(lbl, cond, msg)
`define PSDA_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/psda_pkg.sv @@
package psda_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned DIF_W  = 17;
  localparam int unsigned PRD_W  = 34;
  localparam int unsigned SUM_W  = 35;
  localparam int unsigned DEN_W  = 34;
  localparam int unsigned NUM_W  = 70;
  localparam int unsigned QUO_W  = 36;
  localparam int unsigned ROOT_W = QUO_W / 2;
  localparam int unsigned SREM_W = ROOT_W + 2;
  localparam int unsigned DIST_W = 17;
  localparam int unsigned ANG_W  = 15;

  localparam logic [DIST_W-1:0] DIST_MAX   = 17'd131071;
  localparam logic [DIST_W-1:0] DIST_REACH = 17'd92682;
  localparam int               ANG_MAX    = 11520;

  // CORDIC datapath
  localparam int unsigned CX_W      = 45;
  localparam int unsigned ACC_W     = 24;
  localparam int unsigned NORM_N    = 7;
  localparam int unsigned NORM_EXP  = 40;
  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned ACC_FRAC  = 8;
  localparam logic signed [ACC_W-1:0] DEG90_ACC = 24'sd1474560;
  localparam logic signed [ACC_W-1:0] ACC_RND   = 24'sd128;

  // atan(2^-i) in 2^-14 degree
  localparam logic [19:0] ATAN_TAB [ATAN_LEN] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
    20'd14667, 20'd7334, 20'd3667, 20'd1833, 20'd917, 20'd458,
    20'd229, 20'd115, 20'd57, 20'd29, 20'd14, 20'd7,
    20'd4, 20'd2, 20'd1, 20'd0, 20'd0, 20'd0
  };

  // Shift tried by each normalising step; the last step adds the final single bit.
  localparam int unsigned NORM_SH [NORM_N] = '{32, 16, 8, 4, 2, 1, 1};

  // Operands leaving the front end.
  typedef struct packed {
    logic signed [SUM_W-1:0] dot;
    logic signed [SUM_W-1:0] crs;
    logic                    ang_zero;
    logic [NUM_W-1:0]        num;
    logic [DEN_W-1:0]        den;
  } psda_ops_t;

  // Divider operands carried past the CORDIC.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } psda_div_t;

  function automatic logic [CX_W-1:0] cx_mag(input logic signed [CX_W-1:0] v);
    cx_mag = v[CX_W-1] ? CX_W'(-v) : CX_W'(v);
  endfunction

endpackage

@@ rtl/psda_front.sv @@
module psda_front import psda_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] point_x_i,
  input  logic signed [IN_W-1:0] point_y_i,
  input  logic signed [IN_W-1:0] seg_start_x_i,
  input  logic signed [IN_W-1:0] seg_start_y_i,
  input  logic signed [IN_W-1:0] seg_end_x_i,
  input  logic signed [IN_W-1:0] seg_end_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output psda_ops_t              out_ops_o
);

  localparam int unsigned NST = 5;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  // stage 1: differences
  logic signed [DIF_W-1:0] dx_q, dy_q, wx_q, wy_q, vx_q, vy_q;
  // stage 2: products
  logic signed [PRD_W-1:0] dxdx_q, dydy_q, wxwx_q, wywy_q, vxvx_q, vyvy_q;
  logic signed [PRD_W-1:0] wxdx_q, wydy_q, dxwy_q, dywx_q;
  // stage 3: sums
  logic [DEN_W-1:0]        len2_q, wlen2_q, vlen2_q;
  logic signed [SUM_W-1:0] dot3_q, crs3_q;
  // stage 4: case choice and partial squares of |crs|
  logic [DEN_W-1:0]        sel_q, len4_q;
  logic                    use_c_q, zero4_q;
  logic signed [SUM_W-1:0] dot4_q, crs4_q;
  logic [PRD_W-1:0]        hh_q, hl_q, ll_q;
  // stage 5
  psda_ops_t               ops_q;

  logic                    case_a, case_b;
  logic [DEN_W-1:0]        cmag;
  logic [2*PRD_W-1:0]      c2;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign out_ops_o   = ops_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    case_a = (len2_q == '0) || dot3_q[SUM_W-1];
    case_b = $signed({1'b0, dot3_q}) > $signed({2'b00, len2_q});
    cmag   = crs3_q[SUM_W-1] ? DEN_W'(-crs3_q) : DEN_W'(crs3_q);
    c2     = ({hh_q, 34'd0}) + {16'd0, hl_q, 18'd0} + {34'd0, ll_q};
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dx_q <= DIF_W'(seg_end_x_i) - DIF_W'(seg_start_x_i);
      dy_q <= DIF_W'(seg_end_y_i) - DIF_W'(seg_start_y_i);
      wx_q <= DIF_W'(point_x_i) - DIF_W'(seg_start_x_i);
      wy_q <= DIF_W'(point_y_i) - DIF_W'(seg_start_y_i);
      vx_q <= DIF_W'(point_x_i) - DIF_W'(seg_end_x_i);
      vy_q <= DIF_W'(point_y_i) - DIF_W'(seg_end_y_i);
    end
    if (rdy[1]) begin
      dxdx_q <= PRD_W'(dx_q) * PRD_W'(dx_q);
      dydy_q <= PRD_W'(dy_q) * PRD_W'(dy_q);
      wxwx_q <= PRD_W'(wx_q) * PRD_W'(wx_q);
      wywy_q <= PRD_W'(wy_q) * PRD_W'(wy_q);
      vxvx_q <= PRD_W'(vx_q) * PRD_W'(vx_q);
      vyvy_q <= PRD_W'(vy_q) * PRD_W'(vy_q);
      wxdx_q <= PRD_W'(wx_q) * PRD_W'(dx_q);
      wydy_q <= PRD_W'(wy_q) * PRD_W'(dy_q);
      dxwy_q <= PRD_W'(dx_q) * PRD_W'(wy_q);
      dywx_q <= PRD_W'(dy_q) * PRD_W'(wx_q);
    end
    if (rdy[2]) begin
      len2_q  <= DEN_W'(SUM_W'(dxdx_q) + SUM_W'(dydy_q));
      wlen2_q <= DEN_W'(SUM_W'(wxwx_q) + SUM_W'(wywy_q));
      vlen2_q <= DEN_W'(SUM_W'(vxvx_q) + SUM_W'(vyvy_q));
      dot3_q  <= SUM_W'(wxdx_q) + SUM_W'(wydy_q);
      crs3_q  <= SUM_W'(dxwy_q) - SUM_W'(dywx_q);
    end
    if (rdy[3]) begin
      sel_q   <= case_a ? wlen2_q : vlen2_q;
      use_c_q <= !case_a && !case_b;
      zero4_q <= (len2_q == '0) || (wlen2_q == '0);
      len4_q  <= len2_q;
      dot4_q  <= dot3_q;
      crs4_q  <= crs3_q;
      hh_q    <= PRD_W'(cmag[33:17]) * PRD_W'(cmag[33:17]);
      hl_q    <= PRD_W'(cmag[33:17]) * PRD_W'(cmag[16:0]);
      ll_q    <= PRD_W'(cmag[16:0]) * PRD_W'(cmag[16:0]);
    end
    if (rdy[4]) begin
      ops_q.dot      <= dot4_q;
      ops_q.crs      <= crs4_q;
      ops_q.ang_zero <= zero4_q;
      // The divider forms floor(num / den), which is four times the squared distance.
      ops_q.num      <= use_c_q ? {c2, 2'b00} : {34'd0, sel_q, 2'b00};
      ops_q.den      <= use_c_q ? len4_q : DEN_W'(1);
    end
  end

endmodule

@@ rtl/psda_cordic.sv @@
module psda_cordic import psda_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  psda_ops_t               in_ops_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ANG_W-1:0] out_angle_o,
  output psda_div_t               out_div_o
);

  localparam int unsigned NIT = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int unsigned NST = NORM_N + 2 + NIT;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  logic signed [CX_W-1:0]  x_q   [NST];
  logic signed [CX_W-1:0]  y_q   [NST];
  logic signed [ACC_W-1:0] acc_q [NST];
  logic                    z_q   [NST];
  psda_div_t               div_q [NST];

  logic signed [CX_W-1:0]  x_s   [NST+1];
  logic signed [CX_W-1:0]  y_s   [NST+1];
  logic signed [ACC_W-1:0] acc_s [NST+1];
  logic                    z_s   [NST+1];
  psda_div_t               div_s [NST+1];

  assign x_s[0]   = CX_W'(in_ops_i.dot);
  assign y_s[0]   = CX_W'(in_ops_i.crs);
  assign acc_s[0] = '0;
  assign z_s[0]   = in_ops_i.ang_zero;
  assign div_s[0] = '{num: in_ops_i.num, den: in_ops_i.den};

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign out_angle_o = acc_q[NST-1][ANG_W-1:0];
  assign out_div_o   = div_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic signed [CX_W-1:0]  xn, yn;
    logic signed [ACC_W-1:0] an;

    if (k < NORM_N) begin : g_norm
      // Scale up until the larger magnitude reaches 2^40.
      localparam int unsigned SH = NORM_SH[k];
      localparam logic [CX_W-1:0] LIM =
        (k < NORM_N - 1) ? (CX_W'(1) << (NORM_EXP - SH)) : (CX_W'(1) << NORM_EXP);
      logic [CX_W-1:0] mx, my, mm;
      always_comb begin
        mx = cx_mag(x_s[k]);
        my = cx_mag(y_s[k]);
        mm = (mx > my) ? mx : my;
        an = acc_s[k];
        if (mm < LIM) begin
          xn = x_s[k] <<< SH;
          yn = y_s[k] <<< SH;
        end else begin
          xn = x_s[k];
          yn = y_s[k];
        end
      end
    end else if (k == NORM_N) begin : g_quad
      always_comb begin
        xn = x_s[k];
        yn = y_s[k];
        an = acc_s[k];
        if (x_s[k][CX_W-1]) begin
          if (!y_s[k][CX_W-1]) begin
            xn = y_s[k];
            yn = -x_s[k];
            an = DEG90_ACC;
          end else begin
            xn = -y_s[k];
            yn = x_s[k];
            an = -DEG90_ACC;
          end
        end
      end
    end else if (k < NORM_N + 1 + NIT) begin : g_iter
      localparam int unsigned IT = k - NORM_N - 1;
      localparam logic signed [ACC_W-1:0] ANG = ACC_W'(ATAN_TAB[IT]);
      logic signed [CX_W-1:0] xs, ys;
      always_comb begin
        xs = x_s[k] >>> IT;
        ys = y_s[k] >>> IT;
        if (!y_s[k][CX_W-1] && (y_s[k] != '0)) begin
          xn = x_s[k] + ys;
          yn = y_s[k] - xs;
          an = acc_s[k] + ANG;
        end else begin
          xn = x_s[k] - ys;
          yn = y_s[k] + xs;
          an = acc_s[k] - ANG;
        end
      end
    end else begin : g_rnd
      // Round to 1/64 degree, ties away from zero, then clamp; zero when the zero flag is set.
      logic signed [ACC_W-1:0] r;
      always_comb begin
        xn = x_s[k];
        yn = y_s[k];
        if (!acc_s[k][ACC_W-1]) begin
          r = (acc_s[k] + ACC_RND) >>> ACC_FRAC;
        end else begin
          r = -((-acc_s[k] + ACC_RND) >>> ACC_FRAC);
        end
        if (z_s[k]) begin
          an = '0;
        end else if (r > ACC_W'(ANG_MAX)) begin
          an = ACC_W'(ANG_MAX);
        end else if (r < -ACC_W'(ANG_MAX)) begin
          an = -ACC_W'(ANG_MAX);
        end else begin
          an = r;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        x_q[k]   <= xn;
        y_q[k]   <= yn;
        acc_q[k] <= an;
        z_q[k]   <= z_s[k];
        div_q[k] <= div_s[k];
      end
    end

    assign x_s[k+1]   = x_q[k];
    assign y_s[k+1]   = y_q[k];
    assign acc_s[k+1] = acc_q[k];
    assign z_s[k+1]   = z_q[k];
    assign div_s[k+1] = div_q[k];
  end

endmodule

@@ rtl/psda_div.sv @@
module psda_div import psda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  psda_div_t               in_div_i,
  input  logic signed [ANG_W-1:0] in_angle_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [QUO_W-1:0]        out_quo_o,
  output logic signed [ANG_W-1:0] out_angle_o
);

  localparam int unsigned NST = QUO_W;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  logic [DEN_W-1:0]        rem_q [NST];
  logic [QUO_W-1:0]        nq_q  [NST];
  logic [DEN_W-1:0]        den_q [NST];
  logic signed [ANG_W-1:0] ang_q [NST];

  logic [DEN_W-1:0]        rem_s [NST+1];
  logic [QUO_W-1:0]        nq_s  [NST+1];
  logic [DEN_W-1:0]        den_s [NST+1];
  logic signed [ANG_W-1:0] ang_s [NST+1];

  // The quotient fits in QUO_W bits, so the top of the dividend is already below den.
  assign rem_s[0] = in_div_i.num[NUM_W-1:QUO_W];
  assign nq_s[0]  = in_div_i.num[QUO_W-1:0];
  assign den_s[0] = in_div_i.den;
  assign ang_s[0] = in_angle_i;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign out_quo_o   = nq_q[NST-1];
  assign out_angle_o = ang_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    logic [DEN_W:0] t;
    logic           ge;
    always_comb begin
      t  = {rem_s[k], nq_s[k][QUO_W-1]};
      ge = t >= {1'b0, den_s[k]};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k] <= ge ? DEN_W'(t - {1'b0, den_s[k]}) : DEN_W'(t);
        nq_q[k]  <= {nq_s[k][QUO_W-2:0], ge};
        den_q[k] <= den_s[k];
        ang_q[k] <= ang_s[k];
      end
    end

    assign rem_s[k+1] = rem_q[k];
    assign nq_s[k+1]  = nq_q[k];
    assign den_s[k+1] = den_q[k];
    assign ang_s[k+1] = ang_q[k];
  end

endmodule

@@ rtl/psda_sqrt.sv @@
module psda_sqrt import psda_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [QUO_W-1:0]        in_quo_i,
  input  logic signed [ANG_W-1:0] in_angle_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DIST_W-1:0]       out_dist_o,
  output logic signed [ANG_W-1:0] out_angle_o
);

  localparam int unsigned NST = ROOT_W + 1;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;

  logic [SREM_W-1:0]       rem_q  [ROOT_W];
  logic [ROOT_W-1:0]       root_q [ROOT_W];
  logic [QUO_W-1:0]        qs_q   [ROOT_W];
  logic signed [ANG_W-1:0] ang_q  [ROOT_W];

  logic [SREM_W-1:0]       rem_s  [ROOT_W+1];
  logic [ROOT_W-1:0]       root_s [ROOT_W+1];
  logic [QUO_W-1:0]        qs_s   [ROOT_W+1];
  logic signed [ANG_W-1:0] ang_s  [ROOT_W+1];

  logic [DIST_W-1:0]       dist_q;
  logic signed [ANG_W-1:0] oang_q;
  logic [ROOT_W:0]         half;

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign qs_s[0]   = in_quo_i;
  assign ang_s[0]  = in_angle_i;

  always_comb begin
    rdy[NST] = out_ready_i;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NST-1];
  assign out_dist_o  = dist_q;
  assign out_angle_o = oang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (rdy[k]) begin
          v_q[k] <= (k == 0) ? in_valid_i : v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    logic [SREM_W+1:0] t, trial;
    logic              ge;
    always_comb begin
      t     = {rem_s[k], qs_s[k][QUO_W-1:QUO_W-2]};
      trial = {2'b00, root_s[k], 2'b01};
      ge    = t >= trial;
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        rem_q[k]  <= ge ? SREM_W'(t - trial) : SREM_W'(t);
        root_q[k] <= {root_s[k][ROOT_W-2:0], ge};
        qs_q[k]   <= {qs_s[k][QUO_W-3:0], 2'b00};
        ang_q[k]  <= ang_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q[k];
    assign root_s[k+1] = root_q[k];
    assign qs_s[k+1]   = qs_q[k];
    assign ang_s[k+1]  = ang_q[k];
  end

  // The largest odd integer not above the root is 2n-1, which gives n = (root + 1) / 2.
  assign half = ({1'b0, root_s[ROOT_W]} + (ROOT_W + 1)'(1)) >> 1;

  always_ff @(posedge clk_i) begin
    if (rdy[NST-1]) begin
      dist_q <= (half > (ROOT_W + 1)'(DIST_MAX)) ? DIST_MAX : DIST_W'(half);
      oang_q <= ang_s[ROOT_W];
    end
  end

endmodule

@@ rtl/point_segment_distance_angle.sv @@
// Channel  Dir  Width  Contents
// s_axis   in   96     point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y
// m_axis   out  32     distance, angle
//
// Takes one beat per cycle unless a full pipeline is held by m_axis_tready; a result passes
// the CORDIC chain, the 36 stage divider and the 19 stage square root, placed in series
// behind a five stage front end.
// Reset clears only the valid bits of the pipeline.
// Every stage moves on when the stage after it is empty or moving, so bubbles close up
// and input is still taken while a finished result waits at the output.

`include "point_segment_distance_angle_macros.svh"

module point_segment_distance_angle import psda_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x, point_y, seg_start_x, seg_start_y, seg_end_x, seg_end_y (16 bit each)
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // distance [16:0], angle [31:17]
  output logic [31:0] m_axis_tdata
);

  psda_ops_t               ops;
  psda_div_t               dop;
  logic                    f_valid, f_ready;
  logic                    c_valid, c_ready;
  logic                    d_valid, d_ready;
  logic signed [ANG_W-1:0] c_angle, d_angle, angle;
  logic [QUO_W-1:0]        quo;
  logic [DIST_W-1:0]       distance;

  psda_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .point_x_i     (s_axis_tdata[15:0]),
    .point_y_i     (s_axis_tdata[31:16]),
    .seg_start_x_i (s_axis_tdata[47:32]),
    .seg_start_y_i (s_axis_tdata[63:48]),
    .seg_end_x_i   (s_axis_tdata[79:64]),
    .seg_end_y_i   (s_axis_tdata[95:80]),
    .out_valid_o   (f_valid),
    .out_ready_i   (f_ready),
    .out_ops_o     (ops)
  );

  psda_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_ops_i    (ops),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_angle_o (c_angle),
    .out_div_o   (dop)
  );

  psda_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c_valid),
    .in_ready_o  (c_ready),
    .in_div_i    (dop),
    .in_angle_i  (c_angle),
    .out_valid_o (d_valid),
    .out_ready_i (d_ready),
    .out_quo_o   (quo),
    .out_angle_o (d_angle)
  );

  psda_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d_valid),
    .in_ready_o  (d_ready),
    .in_quo_i    (quo),
    .in_angle_i  (d_angle),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_dist_o  (distance),
    .out_angle_o (angle)
  );

  assign m_axis_tdata = {angle, distance};

  `PSDA_ASSERT_IMP(a_angle_range, m_axis_tvalid, (angle >= -ANG_W'(ANG_MAX)) && (angle <= ANG_W'(ANG_MAX)), "angle outside +-180 degrees")
  `PSDA_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled with room in the pipeline")
  `PSDA_ASSERT_IMP(a_dist_reach, m_axis_tvalid, distance <= DIST_REACH, "distance beyond the reachable range")

endmodule
